/* rtl/cse_pkg.sv */
package cse_pkg;

	localparam int unsigned MAX_CLAUSES_DEF = 256;
	localparam int unsigned MAX_LITS_DEF    = 8;
	localparam int unsigned MAX_VARS_DEF    = 256;

	localparam int unsigned LIT_W  = 10;
	localparam int unsigned NV_W   = 9;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned CNT_OUT_W = 9;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EVAL   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FOLD,
		ST_ROT,
		ST_PACK,
		ST_DONE
	} state_t;

	// per-cycle commands broadcast along the clause chain
	typedef struct packed {
		logic             clear;
		logic             load;
		logic             rotate;
		logic             collapse;
		logic             clr_ct;
		logic             bcast;
		logic [LIT_W-1:0] bmag;
		logic             bbit;
	} cell_ctrl_t;

	function automatic logic [LIT_W-1:0] lit_mag(input logic [LIT_W-1:0] raw);
		lit_mag = raw[LIT_W-1] ? (~raw + 1'b1) : raw;
	endfunction

endpackage

/* rtl/cse_ram.sv */
module cse_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/cse_cell.sv */
module cse_cell #(
	parameter int unsigned MAXL = cse_pkg::MAX_LITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cse_pkg::cell_ctrl_t           ctrl,
	input  logic                          sel,
	input  logic [MAXL*cse_pkg::LIT_W-1:0] ld_lits,
	input  logic [MAXL-1:0]               ld_lv,
	input  logic [MAXL*cse_pkg::LIT_W-1:0] up_lits,
	input  logic [MAXL-1:0]               up_lv,
	input  logic                          up_cv,
	input  logic                          up_ct,
	input  logic                          below_cv,
	output logic [MAXL*cse_pkg::LIT_W-1:0] lits,
	output logic [MAXL-1:0]               lv,
	output logic                          cv,
	output logic                          ct
);

	localparam int unsigned LW = cse_pkg::LIT_W;

	logic hit;
	logic take_up;

	// a literal made true by the broadcast variable marks the clause true
	always_comb begin
		hit = 1'b0;
		for (int j = 0; j < MAXL; j++) begin
			if (lv[j] && (cse_pkg::lit_mag(lits[j*LW +: LW]) == ctrl.bmag)
				&& (ctrl.bbit ^ lits[j*LW + LW - 1])) begin
				hit = 1'b1;
			end
		end
	end

	assign take_up = ctrl.rotate || (ctrl.collapse && !cv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv <= 1'b0;
			ct <= 1'b0;
		end else if (ctrl.clear) begin
			cv <= 1'b0;
			ct <= 1'b0;
		end else if (ctrl.load && sel) begin
			cv <= 1'b1;
			ct <= 1'b0;
		end else if (take_up) begin
			cv <= up_cv;
			ct <= up_ct;
		end else if (ctrl.collapse && !below_cv) begin
			cv <= 1'b0;
		end else if (ctrl.clr_ct) begin
			ct <= 1'b0;
		end else if (ctrl.bcast) begin
			ct <= ct | hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			lits <= ld_lits;
			lv   <= ld_lv;
		end else if (take_up) begin
			lits <= up_lits;
			lv   <= up_lv;
		end
	end

endmodule

/* rtl/cse_head.sv */
module cse_head #(
	parameter int unsigned MAXL = cse_pkg::MAX_LITS_DEF
) (
	input  logic [MAXL*cse_pkg::LIT_W-1:0] lits,
	input  logic [MAXL-1:0]               lv,
	input  logic                          cv,
	input  logic [cse_pkg::LIT_W-1:0]     amag,
	input  logic                          aneg,
	output logic [MAXL-1:0]               o_lv,
	output logic                          keep,
	output logic                          empties
);

	localparam int unsigned LW = cse_pkg::LIT_W;

	logic            sat;
	logic [MAXL-1:0] hitm;

	always_comb begin
		sat  = 1'b0;
		hitm = '0;
		for (int j = 0; j < MAXL; j++) begin
			if (lv[j] && (cse_pkg::lit_mag(lits[j*LW +: LW]) == amag)) begin
				if (lits[j*LW + LW - 1] == aneg) begin
					sat = 1'b1;
				end else begin
					hitm[j] = 1'b1;
				end
			end
		end
	end

	// drop falsified literals; a clause emptied by them is dropped and poisons the formula
	assign o_lv    = lv & ~hitm;
	assign empties = cv && !sat && (|hitm) && (o_lv == '0);
	assign keep    = cv && !sat && !empties;

endmodule

/* rtl/cnf_clause_store_evaluator.sv */
// CNF clause store and evaluator.
// Input stream (s_*): one item per transfer. s_tuser carries the item kind
// (add literal, set variable, evaluate, assign literal, clear), s_tlast closes
// the clause under construction after an add. Output stream (m_*): exactly one
// result transfer per input item, in order.
// Configuration: cfg_data (num_vars) is written on a cfg_valid transfer; write
// it only while no item is in flight.
// Clauses live in a chain of MAX_CLAUSES cells, one clause per cell. An
// evaluate sweeps the assignment RAM once (one variable per cycle, broadcast
// to every cell), then rotates the chain once through the head to AND the
// clause values. An assign rotates the chain once through the head unit,
// which simplifies one clause a cycle, then packs the surviving clauses
// down. Other kinds go straight to the done state. One item is in work
// at a time; the result register lets the next item enter while a result
// waits. A stalled receiver holds the result; the next long item finishes
// its work and then waits until the result register frees up.
// Reset empties the store, clears the false flag and the assignment bitmap,
// and sets num_vars to 256; no clearing pass is needed.
module cnf_clause_store_evaluator #(
	parameter int unsigned MAX_CLAUSES         = cse_pkg::MAX_CLAUSES_DEF,
	parameter int unsigned MAX_LITS_PER_CLAUSE = cse_pkg::MAX_LITS_DEF,
	parameter int unsigned MAX_VARS            = cse_pkg::MAX_VARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // literal[9:0], variable[17:10], value[18], zero fill
	input  logic [2:0]  s_tuser,   // kind[2:0]
	input  logic        s_tlast,   // last_of_clause
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // eval_result[0], formula_false[1], formula_true[2],
	                               // clauses_left[11:3], error[12], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data   // num_vars
);

	localparam int unsigned LW     = cse_pkg::LIT_W;
	localparam int unsigned MAXL   = MAX_LITS_PER_CLAUSE;
	localparam int unsigned N      = MAX_CLAUSES;
	localparam int unsigned TOT_W  = $clog2(N + 1);
	localparam int unsigned BL_W   = $clog2(MAXL + 1);
	localparam int unsigned VA_W   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int unsigned SWEEP  = (MAX_VARS < 512) ? MAX_VARS : 512;
	localparam int unsigned CNT_W  = $clog2(2 * N + SWEEP + 2);
	localparam int unsigned BIG_W  = 18;
	localparam int unsigned CNT_OUT = cse_pkg::CNT_OUT_W;

	// input fields
	logic [2:0]    kind;
	logic [LW-1:0] lit_raw;
	logic [7:0]    var_idx;
	logic          var_val;
	logic [LW-1:0] mag;
	logic          acc;

	assign kind    = s_tuser;
	assign lit_raw = s_tdata[9:0];
	assign var_idx = s_tdata[17:10];
	assign var_val = s_tdata[18];
	assign mag     = cse_pkg::lit_mag(lit_raw);
	assign acc     = s_tvalid && s_tready;

	// state
	cse_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [TOT_W-1:0]  total_q;
	logic [TOT_W-1:0]  kept_q;
	logic [BL_W-1:0]   blen_q;
	logic [MAXL*LW-1:0] blits_q;
	logic              flag_q;
	logic              err_q;
	logic              ev_q;
	logic              and_q;
	logic [cse_pkg::NV_W-1:0] nvars_q;
	logic [LW-1:0]     amag_q;
	logic              aneg_q;
	logic              out_valid_q;
	logic [15:0]       out_q;
	logic [MAX_VARS-1:0] vbits_q;
	logic              rd_s1;
	logic              vld_s1;
	logic [LW-1:0]     rvar_s1;

	// chain
	logic [MAXL*LW-1:0] c_lits [N];
	logic [MAXL-1:0]    c_lv   [N];
	logic               c_cv   [N];
	logic               c_ct   [N];
	cse_pkg::cell_ctrl_t ctrl;

	logic [MAXL*LW-1:0] ld_lits;
	logic [MAXL-1:0]    ld_lv;
	logic [MAXL-1:0]    h_lv;
	logic               h_keep;
	logic               h_empties;
	logic               ram_q;

	// decode
	logic out_free;
	logic lit_oob;
	logic add_full;
	logic add_close0;
	logic add_bad;
	logic add_close;
	logic set_ok;
	logic asn_bad;
	logic done_fire;

	assign out_free  = !out_valid_q || m_tready;
	assign lit_oob   = (BIG_W'(mag) > BIG_W'(nvars_q)) || (BIG_W'(mag) > BIG_W'(MAX_VARS));
	assign add_full  = BIG_W'(total_q) >= BIG_W'(N);
	assign add_close0 = !add_full && (mag == '0);
	assign add_bad   = !add_full && !add_close0
		&& (lit_oob || (BIG_W'(blen_q) >= BIG_W'(MAXL)));
	assign add_close = add_close0 || (!add_full && !add_bad && s_tlast);
	assign set_ok    = BIG_W'(var_idx) < BIG_W'(MAX_VARS);
	assign asn_bad   = (mag == '0) || lit_oob;
	assign done_fire = (state_q == cse_pkg::ST_DONE) && out_free;

	assign s_tready  = (state_q == cse_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// clause image written into the chain when a clause closes
	always_comb begin
		for (int j = 0; j < MAXL; j++) begin
			if (!add_close0 && (BIG_W'(j) == BIG_W'(blen_q))) begin
				ld_lits[j*LW +: LW] = lit_raw;
				ld_lv[j]            = 1'b1;
			end else begin
				ld_lits[j*LW +: LW] = blits_q[j*LW +: LW];
				ld_lv[j]            = BIG_W'(j) < BIG_W'(blen_q);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cse_pkg::ST_IDLE: begin
				if (acc) begin
					if (kind == cse_pkg::KIND_EVAL) begin
						state_d = cse_pkg::ST_SWEEP;
					end else if (kind == cse_pkg::KIND_ASSIGN && !asn_bad) begin
						state_d = cse_pkg::ST_ROT;
					end else begin
						state_d = cse_pkg::ST_DONE;
					end
				end
			end
			cse_pkg::ST_SWEEP: begin
				if (BIG_W'(cnt_q) == BIG_W'(SWEEP)) begin
					state_d = cse_pkg::ST_FOLD;
				end
			end
			cse_pkg::ST_FOLD: begin
				if (BIG_W'(cnt_q) == BIG_W'(N - 1)) begin
					state_d = cse_pkg::ST_DONE;
				end
			end
			cse_pkg::ST_ROT: begin
				if (BIG_W'(cnt_q) == BIG_W'(N - 1)) begin
					state_d = cse_pkg::ST_PACK;
				end
			end
			cse_pkg::ST_PACK: begin
				if (BIG_W'(cnt_q) == BIG_W'(2 * N - 1)) begin
					state_d = cse_pkg::ST_DONE;
				end
			end
			cse_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = cse_pkg::ST_IDLE;
				end
			end
			default: state_d = cse_pkg::ST_IDLE;
		endcase
	end

	// chain commands
	always_comb begin
		ctrl          = '0;
		ctrl.clear    = acc && (kind == cse_pkg::KIND_CLEAR);
		ctrl.load     = acc && (kind == cse_pkg::KIND_ADD) && add_close;
		ctrl.clr_ct   = acc && (kind == cse_pkg::KIND_EVAL);
		ctrl.rotate   = (state_q == cse_pkg::ST_FOLD) || (state_q == cse_pkg::ST_ROT);
		ctrl.collapse = (state_q == cse_pkg::ST_PACK);
		ctrl.bcast    = (state_q == cse_pkg::ST_SWEEP) && rd_s1;
		ctrl.bmag     = rvar_s1 + 1'b1;
		ctrl.bbit     = ram_q && vld_s1;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cse_pkg::ST_IDLE;
			cnt_q       <= '0;
			total_q     <= '0;
			kept_q      <= '0;
			blen_q      <= '0;
			flag_q      <= 1'b0;
			err_q       <= 1'b0;
			ev_q        <= 1'b0;
			and_q       <= 1'b1;
			nvars_q     <= 9'd256;
			out_valid_q <= 1'b0;
			vbits_q     <= '0;
			rd_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				nvars_q <= cfg_data;
			end
			// hold the result until the receiver takes it
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			rd_s1 <= (state_q == cse_pkg::ST_SWEEP) && (BIG_W'(cnt_q) < BIG_W'(SWEEP));

			unique case (state_q)
				cse_pkg::ST_IDLE: begin
					cnt_q  <= '0;
					kept_q <= '0;
					and_q  <= 1'b1;
					if (acc) begin
						err_q <= 1'b0;
						ev_q  <= 1'b0;
						unique case (kind)
							cse_pkg::KIND_ADD: begin
								if (add_full || add_bad) begin
									err_q <= 1'b1;
								end else if (add_close) begin
									total_q <= total_q + 1'b1;
									blen_q  <= '0;
								end else begin
									blen_q <= blen_q + 1'b1;
								end
							end
							cse_pkg::KIND_SET: begin
								if (set_ok) begin
									vbits_q[VA_W'(var_idx)] <= 1'b1;
								end else begin
									err_q <= 1'b1;
								end
							end
							cse_pkg::KIND_ASSIGN: begin
								err_q <= asn_bad;
							end
							cse_pkg::KIND_CLEAR: begin
								total_q <= '0;
								blen_q  <= '0;
								flag_q  <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				cse_pkg::ST_SWEEP: begin
					if (BIG_W'(cnt_q) == BIG_W'(SWEEP)) begin
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				cse_pkg::ST_FOLD: begin
					cnt_q <= cnt_q + 1'b1;
					// fold one clause a cycle as it passes the head
					if (c_cv[0] && !c_ct[0]) begin
						and_q <= 1'b0;
					end
					if (BIG_W'(cnt_q) == BIG_W'(N - 1)) begin
						ev_q <= !flag_q && and_q && !(c_cv[0] && !c_ct[0]);
					end
				end
				cse_pkg::ST_ROT: begin
					if (BIG_W'(cnt_q) == BIG_W'(N - 1)) begin
						cnt_q   <= '0;
						total_q <= kept_q + TOT_W'(h_keep);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
					kept_q <= kept_q + TOT_W'(h_keep);
					if (h_empties) begin
						flag_q <= 1'b1;
					end
				end
				cse_pkg::ST_PACK: begin
					cnt_q <= cnt_q + 1'b1;
				end
				cse_pkg::ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rvar_s1 <= LW'(cnt_q);
		vld_s1  <= vbits_q[VA_W'(cnt_q)];
		if (acc && kind == cse_pkg::KIND_ASSIGN) begin
			amag_q <= mag;
			aneg_q <= lit_raw[LW-1];
		end
		if (acc && kind == cse_pkg::KIND_ADD && !add_full && !add_bad && !add_close) begin
			for (int j = 0; j < MAXL; j++) begin
				if (BIG_W'(j) == BIG_W'(blen_q)) begin
					blits_q[j*LW +: LW] <= lit_raw;
				end
			end
		end
		if (done_fire) begin
			out_q <= {3'b000, err_q, CNT_OUT'(total_q), !flag_q && (total_q == '0),
				flag_q, ev_q};
		end
	end

	// assignment bitmap: data in RAM, written flags in flip-flops
	cse_ram #(
		.WIDTH (1),
		.DEPTH (MAX_VARS),
		.AW    (VA_W)
	) u_bitmap (
		.clk   (clk),
		.we    (acc && (kind == cse_pkg::KIND_SET) && set_ok),
		.waddr (VA_W'(var_idx)),
		.wdata (var_val),
		.raddr (VA_W'(cnt_q)),
		.rdata (ram_q)
	);

	cse_head #(
		.MAXL (MAXL)
	) u_head (
		.lits    (c_lits[0]),
		.lv      (c_lv[0]),
		.cv      (c_cv[0]),
		.amag    (amag_q),
		.aneg    (aneg_q),
		.o_lv    (h_lv),
		.keep    (h_keep),
		.empties (h_empties)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [MAXL*LW-1:0] up_lits;
		logic [MAXL-1:0]    up_lv;
		logic               up_cv;
		logic               up_ct;
		logic               below_cv;

		if (i == N - 1) begin : g_top
			// the head feeds the tail: evaluate passes clauses through, assign rewrites them
			assign up_lits = c_lits[0];
			assign up_lv   = (state_q == cse_pkg::ST_ROT) ? h_lv : c_lv[0];
			assign up_cv   = (state_q == cse_pkg::ST_ROT) ? h_keep
				: ((state_q == cse_pkg::ST_FOLD) && c_cv[0]);
			assign up_ct   = (state_q == cse_pkg::ST_FOLD) && c_ct[0];
		end else begin : g_mid
			assign up_lits = c_lits[i+1];
			assign up_lv   = c_lv[i+1];
			assign up_cv   = c_cv[i+1];
			assign up_ct   = c_ct[i+1];
		end

		if (i == 0) begin : g_bot
			assign below_cv = 1'b1;
		end else begin : g_up
			assign below_cv = c_cv[i-1];
		end

		cse_cell #(
			.MAXL (MAXL)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel      (total_q == TOT_W'(i)),
			.ld_lits  (ld_lits),
			.ld_lv    (ld_lv),
			.up_lits  (up_lits),
			.up_lv    (up_lv),
			.up_cv    (up_cv),
			.up_ct    (up_ct),
			.below_cv (below_cv),
			.lits     (c_lits[i]),
			.lv       (c_lv[i]),
			.cv       (c_cv[i]),
			.ct       (c_ct[i])
		);
	end

`ifndef ASSERT_OFF
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		BIG_W'(total_q) <= BIG_W'(N))
		else $error("clause count above store size");

	a_build_bound: assert property (@(posedge clk) disable iff (!arst_n)
		BIG_W'(blen_q) <= BIG_W'(MAXL))
		else $error("partial clause longer than a cell");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == cse_pkg::KIND_CLEAR) |=> (total_q == '0) && !flag_q && !c_cv[0])
		else $error("clear left clauses or flag behind");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> m_tvalid)
		else $error("finished item did not post a result");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(flag_q) && !$past(acc && kind == cse_pkg::KIND_CLEAR)) |-> flag_q)
		else $error("false flag lost without a clear");
`endif

endmodule
